>>> hdl/upbf_pkg.sv
// ----------------------------------------------------------------------------
// upbf_pkg
// shared types, constants and helpers for the url part boundary finder
// ----------------------------------------------------------------------------
package upbf_pkg;

    localparam int BYTE_W          = 8;
    localparam int OFS_W           = 12;
    localparam int DEFAULT_MAX_LEN = 2048;
    localparam int M_DATA_W        = 80;

    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3a;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2f;
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_QUEST  = 8'h3f;
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [BYTE_W-1:0] data;
    } upbf_item_t;

    typedef struct packed {
        logic scheme_seen;
        logic stopped;
        logic host_start_set;
        logic host_end_set;
        logic path_start_set;
    } upbf_flags_t;

    function automatic logic is_term(input logic [BYTE_W-1:0] c);
        return (c == CH_DOLLAR) || (c == CH_QUEST) || (c == CH_HASH) ||
               (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE) || (c == CH_NUL);
    endfunction

endpackage

>>> hdl/upbf_in_stage.sv
// ----------------------------------------------------------------------------
// upbf_in_stage
// input register for url bytes, refilled in the cycle it drains
// ----------------------------------------------------------------------------
module upbf_in_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [upbf_pkg::BYTE_W-1:0] s_tdata,   // url_byte
    input  logic                        s_tlast,   // last
    input  logic                        advance,
    output upbf_pkg::upbf_item_t        item
);
    import upbf_pkg::*;

    logic              valid_reg;
    logic              last_reg;
    logic [BYTE_W-1:0] data_reg;

    assign s_tready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign item = '{valid: valid_reg, last: last_reg, data: data_reg};

endmodule

>>> hdl/upbf_scan.sv
// ----------------------------------------------------------------------------
// upbf_scan
// examines one character at a given offset and updates the boundary record
// ----------------------------------------------------------------------------
module upbf_scan #(
    parameter int MAX_LEN = upbf_pkg::DEFAULT_MAX_LEN,
    parameter int POS_W   = $clog2(MAX_LEN + 1)
) (
    input  upbf_pkg::upbf_flags_t       i_flags,
    input  logic [POS_W-1:0]            i_proto_end,
    input  logic [POS_W-1:0]            i_host_start,
    input  logic [POS_W-1:0]            i_host_end,
    input  logic [POS_W-1:0]            i_path_start,
    input  logic [POS_W-1:0]            i_stop_pos,
    input  logic [upbf_pkg::BYTE_W-1:0] i_char,
    input  logic [POS_W-1:0]            i_pos,
    input  logic                        i_sep,
    input  logic                        i_en,
    output upbf_pkg::upbf_flags_t       o_flags,
    output logic [POS_W-1:0]            o_proto_end,
    output logic [POS_W-1:0]            o_host_start,
    output logic [POS_W-1:0]            o_host_end,
    output logic [POS_W-1:0]            o_path_start,
    output logic [POS_W-1:0]            o_stop_pos,
    output logic                        o_taken
);
    import upbf_pkg::*;

    localparam logic [POS_W:0] MAX_X = (POS_W + 1)'(MAX_LEN);

    logic [POS_W:0]   pos_plus3;
    logic [POS_W-1:0] proto_clamped;

    assign pos_plus3     = {1'b0, i_pos} + (POS_W + 1)'(3);
    assign proto_clamped = (pos_plus3 > MAX_X) ? MAX_X[POS_W-1:0] : pos_plus3[POS_W-1:0];

    always_comb begin
        o_flags      = i_flags;
        o_proto_end  = i_proto_end;
        o_host_start = i_host_start;
        o_host_end   = i_host_end;
        o_path_start = i_path_start;
        o_stop_pos   = i_stop_pos;
        o_taken      = 1'b0;
        if (i_en && !i_flags.stopped) begin
            priority if (is_term(i_char)) begin
                o_flags.stopped = 1'b1;
                o_stop_pos      = i_pos;
            end else if (!i_flags.scheme_seen && i_sep) begin
                o_flags.scheme_seen    = 1'b1;
                o_proto_end            = proto_clamped;
                o_flags.host_start_set = 1'b1;
                o_host_start           = proto_clamped;
                o_taken                = 1'b1;
            end else if (i_char == CH_COLON) begin
                o_flags.host_end_set = 1'b1;
                o_host_end           = i_pos;
            end else if (i_char == CH_SLASH && !i_flags.path_start_set) begin
                if (!i_flags.host_start_set && i_pos != '0) begin
                    o_flags.host_start_set = 1'b1;
                    o_host_start           = '0;
                end
                if (!i_flags.host_end_set && o_flags.host_start_set) begin
                    o_flags.host_end_set = 1'b1;
                    o_host_end           = i_pos;
                end
                o_flags.path_start_set = 1'b1;
                o_path_start           = i_pos;
            end
        end
    end

endmodule

>>> hdl/upbf_core.sv
// ----------------------------------------------------------------------------
// upbf_core
// scan state, two-byte look-ahead window, end rules and result register
// ----------------------------------------------------------------------------
module upbf_core #(
    parameter int MAX_LEN = upbf_pkg::DEFAULT_MAX_LEN
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  upbf_pkg::upbf_item_t          item,
    output logic                          advance,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [upbf_pkg::M_DATA_W-1:0] m_tdata
);
    import upbf_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam logic [POS_W-1:0] MAX_P = POS_W'(MAX_LEN);

    function automatic logic [OFS_W-1:0] to_ofs(input logic [POS_W-1:0] p);
        logic [POS_W+OFS_W-1:0] w;
        w = {{OFS_W{1'b0}}, p};
        return w[OFS_W-1:0];
    endfunction

    // scan state
    logic [BYTE_W-1:0] held0_reg, held0_next;
    logic [BYTE_W-1:0] held1_reg, held1_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              over_reg, over_next;
    logic              skip_reg, skip_next;
    upbf_flags_t       flags_reg, flags_next;
    logic [POS_W-1:0]  proto_reg, proto_next;
    logic [POS_W-1:0]  hs_reg, hs_next;
    logic [POS_W-1:0]  he_reg, he_next;
    logic [POS_W-1:0]  ps_reg, ps_next;
    logic [POS_W-1:0]  stop_reg, stop_next;

    // result register
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic fire;
    logic fire_last;
    logic run_main;
    logic sep;
    logic [POS_W-1:0] pos_main;

    // chained scan results: a after the main step, b and c after the flush steps
    upbf_flags_t      fa, fb, fc;
    logic [POS_W-1:0] pra, prb, prc;
    logic [POS_W-1:0] hsa, hsb, hsc;
    logic [POS_W-1:0] hea, heb, hec;
    logic [POS_W-1:0] psa, psb, psc;
    logic [POS_W-1:0] sta, stb, stc;
    logic             taken_a, taken_b, taken_c;
    logic [POS_W-1:0] pos_f0, pos_f1;

    // end rules
    logic [POS_W-1:0] end_pos;
    logic             r_hs_set, r_he_set, r_pe_set;
    logic [POS_W-1:0] r_hs, r_he, r_pe;
    logic             hf, pf;

    assign advance   = !item.last || !m_valid_reg || m_tready;
    assign fire      = item.valid && advance;
    assign fire_last = fire && item.last;

    assign run_main = fire && !skip_reg && (cnt_reg == 2'd2);
    assign sep      = (held0_reg == CH_COLON) && (held1_reg == CH_SLASH) &&
                      (item.data == CH_SLASH);
    assign pos_main = over_reg ? MAX_P : pos_reg - POS_W'(2);

    upbf_scan #(.MAX_LEN(MAX_LEN), .POS_W(POS_W)) u_scan_main (
        .i_flags(flags_reg), .i_proto_end(proto_reg), .i_host_start(hs_reg),
        .i_host_end(he_reg), .i_path_start(ps_reg), .i_stop_pos(stop_reg),
        .i_char(held0_reg), .i_pos(pos_main), .i_sep(sep), .i_en(run_main),
        .o_flags(fa), .o_proto_end(pra), .o_host_start(hsa), .o_host_end(hea),
        .o_path_start(psa), .o_stop_pos(sta), .o_taken(taken_a)
    );

    // window and position update for the accepted byte
    logic [BYTE_W-1:0] h0_upd, h1_upd;
    logic [1:0]        cnt_upd;
    logic              skip_upd;
    logic [POS_W-1:0]  pos_upd;
    logic              over_upd;

    always_comb begin
        h0_upd   = held0_reg;
        h1_upd   = held1_reg;
        cnt_upd  = cnt_reg;
        skip_upd = skip_reg;
        if (!flags_reg.stopped) begin
            priority if (skip_reg) begin
                skip_upd = 1'b0;
            end else if (cnt_reg == 2'd2) begin
                priority if (taken_a) begin
                    cnt_upd  = 2'd0;
                    skip_upd = 1'b1;
                end else if (fa.stopped) begin
                    cnt_upd = 2'd0;
                end else begin
                    h0_upd = held1_reg;
                    h1_upd = item.data;
                end
            end else begin
                if (cnt_reg == 2'd0) begin
                    h0_upd = item.data;
                end else begin
                    h1_upd = item.data;
                end
                cnt_upd = cnt_reg + 2'd1;
            end
        end
        if (pos_reg >= MAX_P) begin
            pos_upd  = MAX_P;
            over_upd = 1'b1;
        end else begin
            pos_upd  = pos_reg + POS_W'(1);
            over_upd = over_reg;
        end
    end

    // flush of the held bytes at the end of the url
    assign pos_f0 = over_upd ? MAX_P : pos_upd - {{(POS_W-2){1'b0}}, cnt_upd};
    assign pos_f1 = over_upd ? MAX_P : pos_upd - POS_W'(1);

    upbf_scan #(.MAX_LEN(MAX_LEN), .POS_W(POS_W)) u_scan_flush0 (
        .i_flags(fa), .i_proto_end(pra), .i_host_start(hsa),
        .i_host_end(hea), .i_path_start(psa), .i_stop_pos(sta),
        .i_char(h0_upd), .i_pos(pos_f0), .i_sep(1'b0),
        .i_en(fire_last && cnt_upd != 2'd0),
        .o_flags(fb), .o_proto_end(prb), .o_host_start(hsb), .o_host_end(heb),
        .o_path_start(psb), .o_stop_pos(stb), .o_taken(taken_b)
    );

    upbf_scan #(.MAX_LEN(MAX_LEN), .POS_W(POS_W)) u_scan_flush1 (
        .i_flags(fb), .i_proto_end(prb), .i_host_start(hsb),
        .i_host_end(heb), .i_path_start(psb), .i_stop_pos(stb),
        .i_char(h1_upd), .i_pos(pos_f1), .i_sep(1'b0),
        .i_en(fire_last && cnt_upd == 2'd2),
        .o_flags(fc), .o_proto_end(prc), .o_host_start(hsc), .o_host_end(hec),
        .o_path_start(psc), .o_stop_pos(stc), .o_taken(taken_c)
    );

    always_comb begin
        end_pos  = fc.stopped ? stc : pos_upd;
        r_hs_set = fc.host_start_set;
        r_he_set = fc.host_end_set;
        r_hs     = hsc;
        r_he     = hec;
        r_pe_set = 1'b0;
        r_pe     = '0;
        if (fc.host_start_set && !fc.host_end_set) begin
            r_he_set = 1'b1;
            r_he     = end_pos;
        end else if (fc.path_start_set) begin
            r_pe_set = 1'b1;
            r_pe     = end_pos;
        end
        if (!fc.scheme_seen && !fc.path_start_set) begin
            r_hs_set = 1'b1;
            r_hs     = '0;
            r_he_set = 1'b1;
            r_he     = end_pos;
        end
        hf = r_hs_set && r_he_set;
        pf = fc.path_start_set && r_pe_set;
        m_data_next = '0;
        m_data_next[0]     = fc.scheme_seen;
        m_data_next[12:1]  = fc.scheme_seen ? to_ofs(prc) : '0;
        m_data_next[13]    = hf;
        m_data_next[25:14] = hf ? to_ofs(r_hs) : '0;
        m_data_next[37:26] = hf ? to_ofs(r_he) : '0;
        m_data_next[38]    = pf;
        m_data_next[50:39] = pf ? to_ofs(psc) : '0;
        m_data_next[62:51] = pf ? to_ofs(r_pe) : '0;
        m_data_next[74:63] = to_ofs(end_pos);
        m_data_next[75]    = over_upd;
    end

    always_comb begin
        held0_next = held0_reg;
        held1_next = held1_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        over_next  = over_reg;
        skip_next  = skip_reg;
        flags_next = flags_reg;
        proto_next = proto_reg;
        hs_next    = hs_reg;
        he_next    = he_reg;
        ps_next    = ps_reg;
        stop_next  = stop_reg;
        if (fire) begin
            held0_next = h0_upd;
            held1_next = h1_upd;
            proto_next = pra;
            hs_next    = hsa;
            he_next    = hea;
            ps_next    = psa;
            stop_next  = sta;
            if (item.last) begin
                cnt_next   = 2'd0;
                pos_next   = '0;
                over_next  = 1'b0;
                skip_next  = 1'b0;
                flags_next = '0;
            end else begin
                cnt_next   = cnt_upd;
                pos_next   = pos_upd;
                over_next  = over_upd;
                skip_next  = skip_upd;
                flags_next = fa;
            end
        end
        priority if (fire_last) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= 2'd0;
            pos_reg     <= '0;
            over_reg    <= 1'b0;
            skip_reg    <= 1'b0;
            flags_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            over_reg    <= over_next;
            skip_reg    <= skip_next;
            flags_reg   <= flags_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held0_reg <= held0_next;
        held1_reg <= held1_next;
        proto_reg <= proto_next;
        hs_reg    <= hs_next;
        he_reg    <= he_next;
        ps_reg    <= ps_next;
        stop_reg  <= stop_next;
        if (fire_last) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("held count out of range");

    a_skip_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_reg |-> (cnt_reg == 2'd0) && flags_reg.scheme_seen)
        else $error("skip pending with bytes held or no separator");

    a_over_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        over_reg |-> (pos_reg == MAX_P))
        else $error("overflow without saturated position");

    a_last_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_last |=> (pos_reg == '0) && (flags_reg == '0) && m_valid_reg)
        else $error("state not cleared after url end");

    a_stop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        flags_reg.stopped |-> (cnt_reg == 2'd0) && !skip_reg)
        else $error("window not empty after scan stop");

    a_flush_no_sep: assert property (@(posedge aclk) disable iff (!aresetn)
        !(taken_b || taken_c))
        else $error("separator taken during end flush");

endmodule

>>> hdl/url_part_boundary_finder.sv
// ----------------------------------------------------------------------------
// url_part_boundary_finder
// finds protocol, host and path offsets in a url streamed one byte per request
//
//   channel | dir | tdata                         | tlast
//   s_      | in  | url_byte[7:0]                 | last byte of the url
//   m_      | out | boundary offsets, see m_tdata | -
//
// one byte per cycle except while a held result stalls; input register, then one
// pass of window compare and flag update into the state and result registers
// a result is valid the cycle after its last byte leaves the input register
// synchronous active-low reset clears window, position, flags and result valid
// a held result stalls the input only when the next byte to finish is a last byte
// ----------------------------------------------------------------------------
module url_part_boundary_finder #(
    parameter int MAX_LEN = upbf_pkg::DEFAULT_MAX_LEN
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [upbf_pkg::BYTE_W-1:0]   s_tdata,   // url_byte
    input  logic                          s_tlast,   // last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // protocol_found, proto_limit, host_ok, host_lo, host_hi,
    // path_found, path_lo, path_hi, stop_offset, too_long, zero fill
    output logic [upbf_pkg::M_DATA_W-1:0] m_tdata
);
    import upbf_pkg::*;

    upbf_item_t item;
    logic       advance;

    upbf_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .advance (advance),
        .item    (item)
    );

    upbf_core #(.MAX_LEN(MAX_LEN)) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .advance (advance),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule
